// ===== src/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg: shared constants and types of the poincare section crossing block
// Widths of the fixed-point formats, defaults of the top-level parameters,
// register indexes and the state encodings of the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

   // defaults of the top-level parameters
   localparam int DIMENSIONS_DEFAULT  = 3;
   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int INDEX_WIDTH_DEFAULT = 32;

   // normal vector is signed Q2.14, crossing fraction is unsigned Q0.16
   localparam int NORM_W = 16;
   localparam int FRAC_W = 16;

   // side value grows by the normal width, the difference bit and the sum of three
   localparam int SIDE_GROWTH = NORM_W + 3;

   // fraction divider retires two quotient bits per cycle
   localparam int DIV_BITS_PER_STEP = 2;
   localparam int DIV_STEPS         = FRAC_W / DIV_BITS_PER_STEP;

   // depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_W = 3;

   localparam logic [NORM_W-1:0] NORMAL_Z_RESET = NORM_W'(16384);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PLANE_X  = 3'd0,
      REG_PLANE_Y  = 3'd1,
      REG_PLANE_Z  = 3'd2,
      REG_NORMAL_X = 3'd3,
      REG_NORMAL_Y = 3'd4,
      REG_NORMAL_Z = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MAC  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_DIV  = 5'b00010,
      B_MUL  = 5'b00100,
      B_ADD  = 5'b01000,
      B_DONE = 5'b10000
   } back_state_type;

   // handshake between a producer and the job queue
   typedef struct packed {
      logic push;
      logic full;
   } queue_wr_type;

endpackage

`default_nettype wire

// ===== src/poincare_section_crossing.sv =====
// ----------------------------------------------------------------------------
// poincare_section_crossing: hyperplane crossing detector with interpolation
// Points go in on the req_ queue port: a beat is taken when req_push is high
// and req_full is low. The front forms each side value with one
// multiply-accumulate per coordinate, then classifies it, and takes no new
// point until it is done with the last one.
// A sign change of the side value becomes a job in a two-entry queue. The
// back takes one job at a time through a radix-4 fraction divider, then one
// multiply and one add per coordinate, and waits while the previous result
// beat is still on rsp_. A result beat stays on rsp_ while rsp_empty is low
// and leaves when rsp_pop is high. A stalled receiver stops the back only;
// the front keeps taking points until a crossing finds the job queue full.
// Registers are written through csr_ (always ready) while the block is
// idle; this binds the user, the block itself does not enforce it.
// Reset (synchronous) empties the queues, clears the series state and sets
// the plane point to zero and the normal to unit z.
// ----------------------------------------------------------------------------
`default_nettype none

module poincare_section_crossing
   import psc_pkg::*;
#(
   parameter int DIMENSIONS  = DIMENSIONS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEFAULT,
   localparam int CFG_W = (COORD_WIDTH > NORM_W) ? COORD_WIDTH : NORM_W
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_wdata,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [COORD_WIDTH-1:0] req_point_x,
   input  wire logic [COORD_WIDTH-1:0] req_point_y,
   input  wire logic [COORD_WIDTH-1:0] req_point_z,
   input  wire logic                   req_start_series,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic      [COORD_WIDTH-1:0] rsp_cross_x,
   output logic      [COORD_WIDTH-1:0] rsp_cross_y,
   output logic      [COORD_WIDTH-1:0] rsp_cross_z,
   output logic      [INDEX_WIDTH-1:0] rsp_crossing_index,
   output logic      [FRAC_W-1:0]      rsp_crossing_fraction,
   output logic                        rsp_direction
);

   localparam int SIDE_W  = COORD_WIDTH + SIDE_GROWTH;
   localparam int POINTS_W = DIMENSIONS * COORD_WIDTH;
   localparam int JOB_W   = 2 * POINTS_W + 2 * SIDE_W + INDEX_WIDTH + 1;

   queue_wr_type job_wr;
   logic         job_full;
   logic         job_empty;
   logic         job_pop;

   logic [DIMENSIONS-1:0][COORD_WIDTH-1:0] fr_prev_point, fr_cur_point;
   logic [SIDE_W-1:0]                      fr_prev_mag, fr_cur_mag;
   logic [INDEX_WIDTH-1:0]                 fr_index;
   logic                                   fr_direction;

   logic [DIMENSIONS-1:0][COORD_WIDTH-1:0] bk_prev_point, bk_cur_point;
   logic [SIDE_W-1:0]                      bk_prev_mag, bk_cur_mag;
   logic [INDEX_WIDTH-1:0]                 bk_index;
   logic                                   bk_direction;

   logic [JOB_W-1:0] job_wr_data, job_rd_data;

   psc_front #(
      .DIMENSIONS  (DIMENSIONS),
      .COORD_WIDTH (COORD_WIDTH),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .req_start_series (req_start_series),
      .job_wr           (job_wr),
      .job_full         (job_full),
      .job_prev_point   (fr_prev_point),
      .job_cur_point    (fr_cur_point),
      .job_prev_mag     (fr_prev_mag),
      .job_cur_mag      (fr_cur_mag),
      .job_index        (fr_index),
      .job_direction    (fr_direction)
   );

   assign job_wr_data = {fr_prev_point, fr_cur_point, fr_prev_mag, fr_cur_mag,
                         fr_index, fr_direction};

   psc_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_wr.push),
      .full    (job_full),
      .wr_data (job_wr_data),
      .pop     (job_pop),
      .empty   (job_empty),
      .rd_data (job_rd_data)
   );

   assign {bk_prev_point, bk_cur_point, bk_prev_mag, bk_cur_mag,
           bk_index, bk_direction} = job_rd_data;

   psc_back #(
      .DIMENSIONS  (DIMENSIONS),
      .COORD_WIDTH (COORD_WIDTH),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .job_empty             (job_empty),
      .job_pop               (job_pop),
      .job_prev_point        (bk_prev_point),
      .job_cur_point         (bk_cur_point),
      .job_prev_mag          (bk_prev_mag),
      .job_cur_mag           (bk_cur_mag),
      .job_index             (bk_index),
      .job_direction         (bk_direction),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_cross_x           (rsp_cross_x),
      .rsp_cross_y           (rsp_cross_y),
      .rsp_cross_z           (rsp_cross_z),
      .rsp_crossing_index    (rsp_crossing_index),
      .rsp_crossing_fraction (rsp_crossing_fraction),
      .rsp_direction         (rsp_direction)
   );

endmodule

`default_nettype wire

// ===== src/psc_queue.sv =====
// ----------------------------------------------------------------------------
// psc_queue: short job queue between front and back
// Register-based first-in first-out queue of QUEUE_DEPTH entries with a
// fill count; the head entry is shown while the queue is not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_queue
   import psc_pkg::*;
#(
   parameter int WIDTH = 1,
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push & ~full;
   assign pop_ok  = pop & ~empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/psc_front.sv =====
// ----------------------------------------------------------------------------
// psc_front: point intake and side classification
// Holds the plane registers, forms the side value of each point with one
// multiply-accumulate per dimension, tracks the series state and hands
// every sign change to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_front
   import psc_pkg::*;
#(
   parameter int DIMENSIONS  = DIMENSIONS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEFAULT,
   localparam int SIDE_W = COORD_WIDTH + SIDE_GROWTH,
   localparam int CFG_W  = (COORD_WIDTH > NORM_W) ? COORD_WIDTH : NORM_W
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // register writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]                csr_index,
   input  wire logic [CFG_W-1:0]                      csr_wdata,
   // points
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire logic [COORD_WIDTH-1:0]                req_point_x,
   input  wire logic [COORD_WIDTH-1:0]                req_point_y,
   input  wire logic [COORD_WIDTH-1:0]                req_point_z,
   input  wire logic                                  req_start_series,
   // crossing jobs
   output queue_wr_type                               job_wr,
   input  wire logic                                  job_full,
   output logic      [DIMENSIONS-1:0][COORD_WIDTH-1:0] job_prev_point,
   output logic      [DIMENSIONS-1:0][COORD_WIDTH-1:0] job_cur_point,
   output logic      [SIDE_W-1:0]                     job_prev_mag,
   output logic      [SIDE_W-1:0]                     job_cur_mag,
   output logic      [INDEX_WIDTH-1:0]                job_index,
   output logic                                       job_direction
);

   localparam int DIM_W  = $clog2(DIMENSIONS);
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int MAC_W  = NORM_W + DIFF_W;

   logic [2:0][COORD_WIDTH-1:0] plane_ff;
   logic [2:0][NORM_W-1:0]      normal_ff;
   logic [2:0][COORD_WIDTH-1:0] point_port;

   front_state_type state_ff, state_in;

   logic [DIMENSIONS-1:0][COORD_WIDTH-1:0] point_ff, prev_point_ff;
   logic [DIMENSIONS-1:0][COORD_WIDTH-1:0] plane_use;
   logic [DIMENSIONS-1:0][NORM_W-1:0]      normal_use;
   logic                                   start_ff;
   logic [DIM_W-1:0]                       dim_ff, dim_in;
   logic signed [SIDE_W-1:0]               acc_ff, acc_in;
   logic signed [SIDE_W-1:0]               prev_side_ff;
   logic [INDEX_WIDTH-1:0]                 sample_index_ff;
   logic                                   have_prev_ff;

   logic signed [DIFF_W-1:0] mac_diff;
   logic signed [MAC_W-1:0]  mac_prod;
   logic                     accept;
   logic                     first;
   logic                     prev_pos, prev_neg, cur_pos, cur_neg;
   logic                     crossing;
   logic                     retire;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff  <= '0;
         normal_ff <= {NORMAL_Z_RESET, {(2*NORM_W){1'b0}}};
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_PLANE_X:  plane_ff[0]  <= csr_wdata[COORD_WIDTH-1:0];
            REG_PLANE_Y:  plane_ff[1]  <= csr_wdata[COORD_WIDTH-1:0];
            REG_PLANE_Z:  plane_ff[2]  <= csr_wdata[COORD_WIDTH-1:0];
            REG_NORMAL_X: normal_ff[0] <= csr_wdata[NORM_W-1:0];
            REG_NORMAL_Y: normal_ff[1] <= csr_wdata[NORM_W-1:0];
            REG_NORMAL_Z: normal_ff[2] <= csr_wdata[NORM_W-1:0];
            default: ;
         endcase
      end
   end

   assign point_port = {req_point_z, req_point_y, req_point_x};

   always_comb begin
      for (int i = 0; i < DIMENSIONS; i++) begin
         plane_use[i]  = plane_ff[i];
         normal_use[i] = normal_ff[i];
      end
   end

   // one dimension of the dot product per cycle
   assign mac_diff = $signed({point_ff[dim_ff][COORD_WIDTH-1], point_ff[dim_ff]})
                   - $signed({plane_use[dim_ff][COORD_WIDTH-1], plane_use[dim_ff]});
   assign mac_prod = $signed(normal_use[dim_ff]) * mac_diff;

   assign accept   = req_push & ~req_full;
   assign req_full = (state_ff != F_IDLE);

   assign first    = start_ff | ~have_prev_ff;
   assign prev_neg = prev_side_ff[SIDE_W-1];
   assign prev_pos = ~prev_neg & (prev_side_ff != '0);
   assign cur_neg  = acc_ff[SIDE_W-1];
   assign cur_pos  = ~cur_neg & (acc_ff != '0);
   assign crossing = ~first & ((prev_pos & cur_neg) | (prev_neg & cur_pos));
   assign retire   = (state_ff == F_PUSH) & ~(crossing & job_full);

   assign job_wr.push    = (state_ff == F_PUSH) & crossing & ~job_full;
   assign job_wr.full    = job_full;
   assign job_prev_point = prev_point_ff;
   assign job_cur_point  = point_ff;
   assign job_prev_mag   = prev_neg ? SIDE_W'(-prev_side_ff) : SIDE_W'(prev_side_ff);
   assign job_cur_mag    = cur_neg ? SIDE_W'(-acc_ff) : SIDE_W'(acc_ff);
   assign job_index      = sample_index_ff;
   assign job_direction  = prev_pos;

   always_comb begin
      state_in = state_ff;
      dim_in   = dim_ff;
      acc_in   = acc_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               dim_in   = '0;
               acc_in   = '0;
               state_in = F_MAC;
            end
         end
         F_MAC: begin
            acc_in = acc_ff + SIDE_W'(mac_prod);
            if (dim_ff == DIM_W'(DIMENSIONS - 1)) begin
               state_in = F_PUSH;
            end else begin
               dim_in = dim_ff + 1'b1;
            end
         end
         F_PUSH: begin
            if (retire) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= F_IDLE;
         prev_point_ff   <= '0;
         prev_side_ff    <= '0;
         sample_index_ff <= '0;
         have_prev_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (retire) begin
            prev_point_ff <= point_ff;
            prev_side_ff  <= acc_ff;
            have_prev_ff  <= 1'b1;
            if (first) begin
               sample_index_ff <= '0;
            end else if (sample_index_ff != '1) begin
               sample_index_ff <= sample_index_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dim_ff <= dim_in;
      acc_ff <= acc_in;
      if (accept) begin
         start_ff <= req_start_series;
         for (int i = 0; i < DIMENSIONS; i++) begin
            point_ff[i] <= point_port[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/psc_back.sv =====
// ----------------------------------------------------------------------------
// psc_back: crossing fraction and interpolated point
// Takes one crossing job at a time, divides the earlier side magnitude by
// the sum of both with a radix-4 restoring divider, interpolates each
// coordinate with one multiply and one add, and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_back
   import psc_pkg::*;
#(
   parameter int DIMENSIONS  = DIMENSIONS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEFAULT,
   localparam int SIDE_W = COORD_WIDTH + SIDE_GROWTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // crossing jobs
   input  wire logic                                  job_empty,
   output logic                                       job_pop,
   input  wire logic [DIMENSIONS-1:0][COORD_WIDTH-1:0] job_prev_point,
   input  wire logic [DIMENSIONS-1:0][COORD_WIDTH-1:0] job_cur_point,
   input  wire logic [SIDE_W-1:0]                     job_prev_mag,
   input  wire logic [SIDE_W-1:0]                     job_cur_mag,
   input  wire logic [INDEX_WIDTH-1:0]                job_index,
   input  wire logic                                  job_direction,
   // results
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output logic      [COORD_WIDTH-1:0]                rsp_cross_x,
   output logic      [COORD_WIDTH-1:0]                rsp_cross_y,
   output logic      [COORD_WIDTH-1:0]                rsp_cross_z,
   output logic      [INDEX_WIDTH-1:0]                rsp_crossing_index,
   output logic      [FRAC_W-1:0]                     rsp_crossing_fraction,
   output logic                                       rsp_direction
);

   localparam int DEN_W  = SIDE_W + 1;
   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam int DIM_W  = $clog2(DIMENSIONS);
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;

   back_state_type state_ff, state_in;

   logic [DIMENSIONS-1:0][COORD_WIDTH-1:0] prev_ff, cur_ff, cross_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [DEN_W-1:0]        rem_ff;
   logic [FRAC_W-1:0]       quo_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [DIM_W-1:0]        dim_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [INDEX_WIDTH-1:0]  index_ff;
   logic                    dir_ff;
   logic                    out_valid_ff;

   logic [DEN_W:0]           rem_sh1, rem_sh2;
   logic [DEN_W-1:0]         rem_1, rem_2;
   logic                     bit_1, bit_2;
   logic signed [DIFF_W-1:0] interp_diff;
   logic signed [FRAC_W:0]   frac_s;
   logic signed [PROD_W-1:0] prev_ext;
   logic signed [PROD_W-1:0] interp_sum;
   logic                     load_out;

   // two restoring division steps per cycle
   assign rem_sh1 = {rem_ff, 1'b0};
   assign bit_1   = (rem_sh1 >= {1'b0, den_ff});
   assign rem_1   = bit_1 ? DEN_W'(rem_sh1 - {1'b0, den_ff}) : DEN_W'(rem_sh1);
   assign rem_sh2 = {rem_1, 1'b0};
   assign bit_2   = (rem_sh2 >= {1'b0, den_ff});
   assign rem_2   = bit_2 ? DEN_W'(rem_sh2 - {1'b0, den_ff}) : DEN_W'(rem_sh2);

   assign interp_diff = $signed({cur_ff[dim_ff][COORD_WIDTH-1], cur_ff[dim_ff]})
                      - $signed({prev_ff[dim_ff][COORD_WIDTH-1], prev_ff[dim_ff]});
   assign frac_s      = $signed({1'b0, quo_ff});
   assign prev_ext    = $signed({{(PROD_W-COORD_WIDTH){prev_ff[dim_ff][COORD_WIDTH-1]}},
                                 prev_ff[dim_ff]});
   // arithmetic shift gives the floor of the scaled step
   assign interp_sum  = prev_ext + (prod_ff >>> FRAC_W);

   assign job_pop  = (state_ff == B_IDLE) & ~job_empty;
   assign load_out = (state_ff == B_DONE) & ~out_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!job_empty) state_in = B_DIV;
         B_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = B_MUL;
            end
         end
         B_MUL: state_in = B_ADD;
         B_ADD: begin
            state_in = (dim_ff == DIM_W'(DIMENSIONS - 1)) ? B_DONE : B_MUL;
         end
         B_DONE: if (load_out) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            if (job_pop) begin
               prev_ff  <= job_prev_point;
               cur_ff   <= job_cur_point;
               den_ff   <= {1'b0, job_prev_mag} + {1'b0, job_cur_mag};
               rem_ff   <= {1'b0, job_prev_mag};
               quo_ff   <= '0;
               step_ff  <= '0;
               index_ff <= job_index;
               dir_ff   <= job_direction;
            end
         end
         B_DIV: begin
            rem_ff  <= rem_2;
            quo_ff  <= {quo_ff[FRAC_W-3:0], bit_1, bit_2};
            step_ff <= step_ff + 1'b1;
            dim_ff  <= '0;
         end
         B_MUL: prod_ff <= interp_diff * frac_s;
         B_ADD: begin
            cross_ff[dim_ff] <= interp_sum[COORD_WIDTH-1:0];
            if (dim_ff != DIM_W'(DIMENSIONS - 1)) begin
               dim_ff <= dim_ff + 1'b1;
            end
         end
         B_DONE: ;
         default: ;
      endcase
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_cross_x           <= cross_ff[0];
         rsp_cross_y           <= cross_ff[1];
         rsp_crossing_index    <= index_ff;
         rsp_crossing_fraction <= quo_ff;
         rsp_direction         <= dir_ff;
      end
   end

   generate
      if (DIMENSIONS > 2) begin : g_z
         always_ff @(posedge clock) begin
            if (load_out) begin
               rsp_cross_z <= cross_ff[DIMENSIONS-1];
            end
         end
      end else begin : g_no_z
         assign rsp_cross_z = '0;
      end
   endgenerate

   assign rsp_empty = ~out_valid_ff;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: poincare section crossing detector
// Streams trajectory points through the req_ queue port under several plane
// and normal settings, predicts every crossing (side value, truncated
// fraction, floor-interpolated point, index and direction) and checks each
// rsp_ beat against the oldest predicted crossing, with random idling on
// both sides, a long receiver stall and a watchdog on lack of progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import psc_pkg::*;
();

   localparam int COORD_W     = COORD_WIDTH_DEFAULT;
   localparam int INDEX_W     = INDEX_WIDTH_DEFAULT;
   localparam int CSR_DATA_W  = (COORD_W > NORM_W) ? COORD_W : NORM_W;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 48;

   // indexes past the last register, writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               start;
   } point_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [INDEX_W-1:0] index;
      logic [FRAC_W-1:0]  fraction;
      logic               direction;
   } crossing_type;

   class crossing_tracker;
      logic signed [COORD_W-1:0] plane[3];
      logic signed [NORM_W-1:0]  normal[3];
      longint                    prev_point[3];
      longint                    prev_side;
      logic [INDEX_W-1:0]        sample_index;
      bit                        have_previous;
      crossing_type              pending_crossings[$];
      int                        errors;

      function new();
         for (int i = 0; i < 3; i++) begin
            plane[i] = '0;
            normal[i] = '0;
            prev_point[i] = 0;
         end
         normal[2] = NORMAL_Z_RESET;
         prev_side = 0;
         sample_index = '0;
         have_previous = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_PLANE_X:  plane[0] = data[COORD_W-1:0];
            REG_PLANE_Y:  plane[1] = data[COORD_W-1:0];
            REG_PLANE_Z:  plane[2] = data[COORD_W-1:0];
            REG_NORMAL_X: normal[0] = data[NORM_W-1:0];
            REG_NORMAL_Y: normal[1] = data[NORM_W-1:0];
            REG_NORMAL_Z: normal[2] = data[NORM_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_crossings.size();
      endfunction

      function void take_point(point_type p);
         longint             cur[3];
         longint             side;
         longint             ap;
         longint             ac;
         longint             frac;
         logic [COORD_W-1:0] at[3];
         logic [INDEX_W-1:0] next_index;
         crossing_type       c;
         cur[0] = longint'($signed(p.x));
         cur[1] = longint'($signed(p.y));
         cur[2] = longint'($signed(p.z));
         side = 0;
         for (int i = 0; i < 3; i++)
            side += longint'(normal[i]) * (cur[i] - longint'(plane[i]));
         if (p.start || !have_previous) begin
            next_index = '0;
         end else begin
            next_index = (sample_index == '1) ? sample_index : sample_index + 1'b1;
            // a zero side value never counts as a crossing
            if ((prev_side > 0 && side < 0) || (prev_side < 0 && side > 0)) begin
               ap = (prev_side > 0) ? prev_side : -prev_side;
               ac = (side > 0) ? side : -side;
               frac = (ap <<< FRAC_W) / (ap + ac);
               for (int i = 0; i < 3; i++)
                  at[i] = COORD_W'(prev_point[i] + (((cur[i] - prev_point[i]) * frac) >>> FRAC_W));
               c.x = at[0];
               c.y = at[1];
               c.z = at[2];
               c.index = sample_index;
               c.fraction = frac[FRAC_W-1:0];
               c.direction = (prev_side > 0);
               pending_crossings = {pending_crossings, c};
            end
         end
         for (int i = 0; i < 3; i++)
            prev_point[i] = cur[i];
         prev_side = side;
         sample_index = next_index;
         have_previous = 1;
      endfunction

      function void compare(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_crossing(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                   logic [COORD_W-1:0] z, logic [INDEX_W-1:0] index,
                                   logic [FRAC_W-1:0] fraction, logic direction);
         crossing_type c;
         if (pending_crossings.size() == 0) begin
            errors++;
            $display("%0t: unexpected crossing, index %0h fraction %0h", $time, index, fraction);
            return;
         end
         c = pending_crossings.pop_front();
         compare("cross_x", c.x, x);
         compare("cross_y", c.y, y);
         compare("cross_z", c.z, z);
         compare("crossing_index", c.index, index);
         compare("crossing_fraction", c.fraction, fraction);
         compare("direction", c.direction, direction);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_push;
   logic                   req_full;
   logic [COORD_W-1:0]     req_point_x;
   logic [COORD_W-1:0]     req_point_y;
   logic [COORD_W-1:0]     req_point_z;
   logic                   req_start_series;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [COORD_W-1:0]     rsp_cross_x;
   logic [COORD_W-1:0]     rsp_cross_y;
   logic [COORD_W-1:0]     rsp_cross_z;
   logic [INDEX_W-1:0]     rsp_crossing_index;
   logic [FRAC_W-1:0]      rsp_crossing_fraction;
   logic                   rsp_direction;

   logic                   hold_request;
   int                     quiet_cycles = 0;
   crossing_tracker        sb = new();

   poincare_section_crossing i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_point_x           (req_point_x),
      .req_point_y           (req_point_y),
      .req_point_z           (req_point_z),
      .req_start_series      (req_start_series),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_cross_x           (rsp_cross_x),
      .rsp_cross_y           (rsp_cross_y),
      .rsp_cross_z           (rsp_cross_z),
      .rsp_crossing_index    (rsp_crossing_index),
      .rsp_crossing_fraction (rsp_crossing_fraction),
      .rsp_direction         (rsp_direction)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side: checks each popped beat, pops in random stretches
   initial begin : crossing_sink
      int stretch_left;
      int r;
      rsp_pop = 1'b0;
      stretch_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            sb.check_crossing(rsp_cross_x, rsp_cross_y, rsp_cross_z, rsp_crossing_index,
                              rsp_crossing_fraction, rsp_direction);
         if (hold_request) begin
            hold_request <= 1'b0;
            rsp_pop <= 1'b0;
            stretch_left = HOLD_CYCLES;
         end else if (stretch_left > 0) begin
            stretch_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               rsp_pop <= 1'b1;
               stretch_left = $urandom_range(0, 30);
            end else if (r < 80) begin
               rsp_pop <= 1'b0;
               stretch_left = $urandom_range(0, 3);
            end else if (r < 95) begin
               rsp_pop <= 1'b1;
               stretch_left = $urandom_range(40, 100);
            end else begin
               rsp_pop <= 1'b0;
               stretch_left = $urandom_range(8, 40);
            end
         end
      end
   end

   function automatic point_type pt(int x, int y, int z, bit s);
      point_type p;
      p.x = COORD_W'(x);
      p.y = COORD_W'(y);
      p.z = COORD_W'(z);
      p.start = s;
      return p;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic point_type random_point();
      point_type          p;
      logic [COORD_W-1:0] c[3];
      int                 mode;
      mode = $urandom_range(0, 99);
      for (int i = 0; i < 3; i++) begin
         if (mode < 40) begin
            c[i] = COORD_W'($urandom);
         end else if (mode < 80) begin
            // close to the plane point: small side values, fractions near the ends
            c[i] = COORD_W'(sb.plane[i] + $urandom_range(0, 16) - 8);
         end else if (mode < 90) begin
            c[i] = sb.plane[i];
         end else begin
            case ($urandom_range(0, 3))
               0: c[i] = {1'b1, {(COORD_W-1){1'b0}}};
               1: c[i] = {1'b0, {(COORD_W-1){1'b1}}};
               2: c[i] = '0;
               default: c[i] = '1;
            endcase
         end
      end
      p.x = c[0];
      p.y = c[1];
      p.z = c[2];
      p.start = ($urandom_range(0, 99) < 4);
      return p;
   endfunction

   task automatic send_point(point_type p);
      req_push <= 1'b1;
      req_point_x <= p.x;
      req_point_y <= p.y;
      req_point_z <= p.z;
      req_start_series <= p.start;
      do @(posedge clock); while (req_full);
      sb.take_point(p);
   endtask

   task automatic idle_sender(int gap);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(int setting);
      logic [CSR_DATA_W-1:0] pl[3];
      logic [CSR_DATA_W-1:0] nm[3];
      for (int i = 0; i < 3; i++) begin
         pl[i] = CSR_DATA_W'($urandom);
         nm[i] = CSR_DATA_W'($urandom);
      end
      case (setting)
         1: for (int i = 0; i < 3; i++) begin
               pl[i] = 16'h8000;
               nm[i] = 16'h7fff;
            end
         2: for (int i = 0; i < 3; i++) begin
               pl[i] = 16'h7fff;
               nm[i] = 16'h8000;
            end
         3: for (int i = 0; i < 3; i++)
               nm[i] = '0;
         4: begin
               nm[0] = '0;
               nm[1] = '0;
               nm[2] = '0;
               nm[$urandom_range(0, 2)] = CSR_DATA_W'($urandom);
            end
         5: for (int i = 0; i < 3; i++)
               pl[i] = CSR_DATA_W'($urandom_range(0, 2047) - 1024);
         6: begin
               pl[0] = '0;
               pl[1] = '0;
               pl[2] = '0;
               nm[0] = 16'h8000;
               nm[1] = 16'h7fff;
               nm[2] = 16'h0001;
            end
         default: ;
      endcase
      write_reg(REG_PLANE_X, pl[0]);
      write_reg(REG_PLANE_Y, pl[1]);
      write_reg(REG_PLANE_Z, pl[2]);
      write_reg(REG_NORMAL_X, nm[0]);
      write_reg(REG_NORMAL_Y, nm[1]);
      write_reg(REG_NORMAL_Z, nm[2]);
      write_reg(REG_SPARE_6, CSR_DATA_W'($urandom));
      write_reg(REG_SPARE_7, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin : point_source
      point_type directed[$];
      int        gap;
      int        rush_left;
      int        n;
      bit        steady;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_push = 1'b0;
      req_point_x = '0;
      req_point_y = '0;
      req_point_z = '0;
      req_start_series = 1'b0;
      hold_request = 1'b0;
      rush_left = 0;
      steady = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: unit z normal through the origin, side follows z
      directed = '{pt(0, 0, 100, 1), pt(10, 20, -100, 0), pt(-32768, 32767, 32767, 0),
                   pt(32767, -32768, -32768, 0), pt(0, 0, 0, 0), pt(5, 5, 5, 0),
                   pt(1, 1, -1, 1), pt(-1, -1, 1, 0), pt(100, -100, 1, 0),
                   pt(-100, 100, -32768, 0), pt(7, 7, 32767, 0), pt(0, 0, -1, 0),
                   pt(0, 0, 0, 1), pt(-5, 3, -1, 0), pt(300, -300, 1, 0)};
      foreach (directed[i]) begin
         idle_sender(pick_gap());
         send_point(directed[i]);
      end

      for (int setting = 0; setting < 7; setting++) begin
         drain_results();
         repeat (SETTLE) @(posedge clock);
         configure(setting);
         n = (setting == 3) ? 60 : 250;
         for (int k = 0; k < n; k++) begin
            if (setting == 0 && k == 50) begin
               // receiver stalls while points keep coming until the input backs up
               hold_request <= 1'b1;
               rush_left = 40;
            end
            if (setting == 2 && k == 120)
               drain_results();
            if (k % 64 == 0)
               steady = ($urandom_range(0, 9) < 2);
            gap = (steady || rush_left > 0) ? 0 : pick_gap();
            if (rush_left > 0)
               rush_left--;
            idle_sender(gap);
            send_point(random_point());
         end
      end

      drain_results();
      repeat (60) @(posedge clock);
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/psc_pkg.sv
src/psc_queue.sv
src/psc_front.sv
src/psc_back.sv
src/poincare_section_crossing.sv
tb/testbench.sv
